// ----- design/bfcd_pkg.sv -----
`timescale 1ns / 1ps
package bfcd_pkg;

	localparam int unsigned SECTOR_SHIFT     = 12;
	localparam int unsigned SECTOR_BYTES     = 1 << SECTOR_SHIFT;
	localparam int unsigned SECTORS_PER_BANK = 16;
	localparam int unsigned BANK_COUNT       = 2;
	localparam int unsigned BANK_BYTES       = SECTOR_BYTES * SECTORS_PER_BANK;
	localparam int unsigned ARRAY_BYTES      = BANK_BYTES * BANK_COUNT;
	localparam int unsigned MEM_AW           = $clog2(ARRAY_BYTES);

	localparam logic        ACC_READ  = 1'b0;
	localparam logic        ACC_WRITE = 1'b1;

	localparam logic [15:0] ADDR_UNLOCK_A = 16'h5555;
	localparam logic [15:0] ADDR_UNLOCK_B = 16'h2AAA;
	localparam logic [15:0] ADDR_BANK     = 16'h0000;
	localparam logic [7:0]  DATA_UNLOCK_A = 8'hAA;
	localparam logic [7:0]  DATA_UNLOCK_B = 8'h55;
	localparam logic [7:0]  CMD_BANK      = 8'hB0;
	localparam logic [7:0]  CMD_ERASE     = 8'h80;
	localparam logic [7:0]  CMD_PROGRAM   = 8'hA0;
	localparam logic [7:0]  DATA_CONFIRM  = 8'h30;
	localparam logic [7:0]  DATA_ERASED   = 8'hFF;
	localparam logic [7:0]  DATA_ZERO     = 8'h00;

	typedef enum logic [2:0] {
		SEQ_IDLE,
		SEQ_FIRST,
		SEQ_UNLOCKED,
		SEQ_OPERAND,
		SEQ_ERASE_AA,
		SEQ_ERASE_55
	} seq_stage_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_BANK,
		OP_PROGRAM,
		OP_ERASE
	} op_t;

	typedef enum logic [2:0] {
		EV_NONE,
		EV_BANK,
		EV_ERASE,
		EV_PROGRAM,
		EV_ABORT
	} event_t;

	typedef enum logic [2:0] {
		CS_CLEAR,
		CS_IDLE,
		CS_PROGRAM,
		CS_ERASE,
		CS_FINISH
	} ctrl_state_t;

	typedef struct packed {
		event_t ev;
		logic   prog;
		logic   erase;
	} seq_dec_t;

	typedef struct packed {
		logic clear_step;
		logic accept;
		logic start_erase;
		logic prog_write;
		logic erase_step;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic clear_done;
		logic sector_done;
		logic out_free;
	} dp_sts_t;

	function automatic logic in_bank(logic [15:0] addr);
		return 32'(addr) < BANK_BYTES;
	endfunction

	function automatic logic [MEM_AW-1:0] mem_index(logic bank, logic [15:0] addr);
		logic [31:0] base;
		base = bank ? BANK_BYTES : 32'd0;
		return MEM_AW'(base + 32'(addr));
	endfunction

endpackage

// ----- design/bfcd_req_if.sv -----
`timescale 1ns / 1ps
interface bfcd_req_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [15:0] address;
	logic [7:0]  write_data;

	modport source(output valid, output cmd, output address, output write_data, input ready);
	modport sink(input valid, input cmd, input address, input write_data, output ready);
endinterface

// ----- design/bfcd_rsp_if.sv -----
`timescale 1ns / 1ps
interface bfcd_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic [2:0] event_res;

	modport source(output valid, output read_data, output event_res, input ready);
	modport sink(input valid, input read_data, input event_res, output ready);
endinterface

// ----- design/bfcd_seq.sv -----
`timescale 1ns / 1ps
module bfcd_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               update,
	input  logic [15:0]        address,
	input  logic [7:0]         write_data,
	output bfcd_pkg::seq_dec_t dec,
	output logic               bank
);

	bfcd_pkg::seq_stage_t stage_q, stage_d;
	bfcd_pkg::op_t        op_q, op_d;
	logic                 bank_q, bank_d;
	logic                 is_unlock_a, is_unlock_b, addr_ok;

	assign is_unlock_a = (address == bfcd_pkg::ADDR_UNLOCK_A) &&
		(write_data == bfcd_pkg::DATA_UNLOCK_A);
	assign is_unlock_b = (address == bfcd_pkg::ADDR_UNLOCK_B) &&
		(write_data == bfcd_pkg::DATA_UNLOCK_B);
	assign addr_ok = bfcd_pkg::in_bank(address);
	assign bank    = bank_q;

	always_comb begin
		stage_d = bfcd_pkg::SEQ_IDLE;
		op_d    = bfcd_pkg::OP_NONE;
		bank_d  = bank_q;
		case (stage_q)
			bfcd_pkg::SEQ_IDLE: begin
				if (is_unlock_a) begin
					stage_d = bfcd_pkg::SEQ_FIRST;
				end
			end
			bfcd_pkg::SEQ_FIRST: begin
				if (is_unlock_b) begin
					stage_d = bfcd_pkg::SEQ_UNLOCKED;
				end
			end
			bfcd_pkg::SEQ_UNLOCKED: begin
				if (address == bfcd_pkg::ADDR_UNLOCK_A) begin
					if (write_data == bfcd_pkg::CMD_BANK) begin
						stage_d = bfcd_pkg::SEQ_OPERAND;
						op_d    = bfcd_pkg::OP_BANK;
					end else if (write_data == bfcd_pkg::CMD_PROGRAM) begin
						stage_d = bfcd_pkg::SEQ_OPERAND;
						op_d    = bfcd_pkg::OP_PROGRAM;
					end else if (write_data == bfcd_pkg::CMD_ERASE) begin
						stage_d = bfcd_pkg::SEQ_ERASE_AA;
						op_d    = bfcd_pkg::OP_ERASE;
					end
				end
			end
			bfcd_pkg::SEQ_ERASE_AA: begin
				if (is_unlock_a) begin
					stage_d = bfcd_pkg::SEQ_ERASE_55;
					op_d    = op_q;
				end
			end
			bfcd_pkg::SEQ_ERASE_55: begin
				if (is_unlock_b) begin
					stage_d = bfcd_pkg::SEQ_OPERAND;
					op_d    = op_q;
				end
			end
			bfcd_pkg::SEQ_OPERAND: begin
				if (op_q == bfcd_pkg::OP_BANK && address == bfcd_pkg::ADDR_BANK) begin
					bank_d = (32'(write_data[0]) < bfcd_pkg::BANK_COUNT) ? write_data[0] : 1'b0;
				end
			end
			default: begin
				stage_d = bfcd_pkg::SEQ_IDLE;
			end
		endcase
	end

	always_comb begin
		dec = '{ev: bfcd_pkg::EV_ABORT, prog: 1'b0, erase: 1'b0};
		case (stage_q)
			bfcd_pkg::SEQ_IDLE: begin
				dec.ev = bfcd_pkg::EV_NONE;
			end
			bfcd_pkg::SEQ_FIRST, bfcd_pkg::SEQ_ERASE_55: begin
				if (is_unlock_b) begin
					dec.ev = bfcd_pkg::EV_NONE;
				end
			end
			bfcd_pkg::SEQ_ERASE_AA: begin
				if (is_unlock_a) begin
					dec.ev = bfcd_pkg::EV_NONE;
				end
			end
			bfcd_pkg::SEQ_UNLOCKED: begin
				if (address == bfcd_pkg::ADDR_UNLOCK_A && (write_data inside
					{bfcd_pkg::CMD_BANK, bfcd_pkg::CMD_PROGRAM, bfcd_pkg::CMD_ERASE})) begin
					dec.ev = bfcd_pkg::EV_NONE;
				end
			end
			bfcd_pkg::SEQ_OPERAND: begin
				case (op_q)
					bfcd_pkg::OP_BANK: begin
						if (address == bfcd_pkg::ADDR_BANK) begin
							dec.ev = bfcd_pkg::EV_BANK;
						end
					end
					bfcd_pkg::OP_PROGRAM: begin
						if (addr_ok) begin
							dec.ev   = bfcd_pkg::EV_PROGRAM;
							dec.prog = 1'b1;
						end
					end
					bfcd_pkg::OP_ERASE: begin
						if (addr_ok && write_data == bfcd_pkg::DATA_CONFIRM) begin
							dec.ev    = bfcd_pkg::EV_ERASE;
							dec.erase = 1'b1;
						end
					end
					default: begin
						dec.ev = bfcd_pkg::EV_ABORT;
					end
				endcase
			end
			default: begin
				dec.ev = bfcd_pkg::EV_ABORT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= bfcd_pkg::SEQ_IDLE;
			op_q    <= bfcd_pkg::OP_NONE;
			bank_q  <= 1'b0;
		end else if (update) begin
			stage_q <= stage_d;
			op_q    <= op_d;
			bank_q  <= bank_d;
		end
	end

endmodule

// ----- design/bfcd_ctrl.sv -----
`timescale 1ns / 1ps
module bfcd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic               is_write,
	input  bfcd_pkg::seq_dec_t dec,
	input  bfcd_pkg::dp_sts_t  sts,
	output logic               req_ready,
	output bfcd_pkg::dp_cmd_t  cmd
);

	bfcd_pkg::ctrl_state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			bfcd_pkg::CS_CLEAR: begin
				if (sts.clear_done) begin
					state_d = bfcd_pkg::CS_IDLE;
				end
			end
			bfcd_pkg::CS_IDLE: begin
				if (req_valid) begin
					if (is_write && dec.prog) begin
						state_d = bfcd_pkg::CS_PROGRAM;
					end else if (is_write && dec.erase) begin
						state_d = bfcd_pkg::CS_ERASE;
					end else begin
						state_d = bfcd_pkg::CS_FINISH;
					end
				end
			end
			bfcd_pkg::CS_PROGRAM: begin
				state_d = bfcd_pkg::CS_FINISH;
			end
			bfcd_pkg::CS_ERASE: begin
				if (sts.sector_done) begin
					state_d = bfcd_pkg::CS_FINISH;
				end
			end
			bfcd_pkg::CS_FINISH: begin
				if (sts.out_free) begin
					state_d = bfcd_pkg::CS_IDLE;
				end
			end
			default: begin
				state_d = bfcd_pkg::CS_CLEAR;
			end
		endcase
	end

	always_comb begin
		req_ready       = (state_q == bfcd_pkg::CS_IDLE);
		cmd.clear_step  = (state_q == bfcd_pkg::CS_CLEAR);
		cmd.accept      = req_ready && req_valid;
		cmd.start_erase = cmd.accept && is_write && dec.erase;
		cmd.prog_write  = (state_q == bfcd_pkg::CS_PROGRAM);
		cmd.erase_step  = (state_q == bfcd_pkg::CS_ERASE);
		cmd.out_load    = (state_q == bfcd_pkg::CS_FINISH) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfcd_pkg::CS_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- design/bfcd_dp.sv -----
`timescale 1ns / 1ps
module bfcd_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  bfcd_pkg::dp_cmd_t cmd,
	input  logic              is_write,
	input  logic [15:0]       address,
	input  logic [7:0]        write_data,
	input  logic              bank,
	input  bfcd_pkg::event_t  ev,
	input  logic              rsp_ready,
	output bfcd_pkg::dp_sts_t sts,
	output logic              rsp_valid,
	output logic [7:0]        rsp_read_data,
	output logic [2:0]        rsp_event_res
);

	logic [7:0]                  flash_q [bfcd_pkg::ARRAY_BYTES];
	logic [7:0]                  rd_q;
	logic [bfcd_pkg::MEM_AW-1:0] idx;
	logic [bfcd_pkg::MEM_AW-1:0] sweep_q;
	logic [bfcd_pkg::MEM_AW-1:0] addr_q;
	logic [7:0]                  data_q;
	logic                        is_read_q, in_rng_q, in_rng;
	bfcd_pkg::event_t            ev_q;
	logic                        out_valid_q;
	logic [7:0]                  out_data_q;
	bfcd_pkg::event_t            out_ev_q;
	logic                        we;
	logic [bfcd_pkg::MEM_AW-1:0] waddr;
	logic [7:0]                  wdata;

	assign idx    = bfcd_pkg::mem_index(bank, address);
	assign in_rng = bfcd_pkg::in_bank(address);

	always_comb begin
		we    = 1'b0;
		waddr = sweep_q;
		wdata = bfcd_pkg::DATA_ERASED;
		if (cmd.clear_step || cmd.erase_step) begin
			we = 1'b1;
		end else if (cmd.prog_write) begin
			we    = 1'b1;
			waddr = addr_q;
			wdata = rd_q & data_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			flash_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && in_rng) begin
			rd_q <= flash_q[idx];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			addr_q    <= idx;
			data_q    <= write_data;
			is_read_q <= !is_write;
			in_rng_q  <= in_rng;
			ev_q      <= is_write ? ev : bfcd_pkg::EV_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else if (cmd.start_erase) begin
			sweep_q <= idx & ~bfcd_pkg::MEM_AW'(bfcd_pkg::SECTOR_BYTES - 1);
		end else if (cmd.clear_step || cmd.erase_step) begin
			sweep_q <= sweep_q + 1'b1;
		end
	end

	assign sts.clear_done  = (sweep_q == bfcd_pkg::MEM_AW'(bfcd_pkg::ARRAY_BYTES - 1));
	assign sts.sector_done = &sweep_q[bfcd_pkg::SECTOR_SHIFT-1:0];
	assign sts.out_free    = !out_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_ev_q   <= ev_q;
			out_data_q <= !is_read_q ? bfcd_pkg::DATA_ZERO :
				(in_rng_q ? rd_q : bfcd_pkg::DATA_ERASED);
		end
	end

	assign rsp_valid     = out_valid_q;
	assign rsp_read_data = out_data_q;
	assign rsp_event_res = out_ev_q;

endmodule

// ----- design/banked_flash_command_decoder_unit.sv -----
`timescale 1ns / 1ps
// Banked flash command decoder: a byte-wide model of a two-bank flash part.
// req carries one bus access per transfer (cmd 0 read, 1 write, a 16-bit
// in-bank address and the write byte); rsp returns one result per access:
// the byte read (zero on writes) and an event code.
// After reset the array is swept to FF, one byte a cycle, across all
// ARRAY_BYTES (131072) bytes; req.ready stays low for that whole pass.
// A byte program is a read-modify-write: the byte is read when the request
// is taken and written back ANDed with the write byte. A sector erase
// writes FF over the whole sector, one byte written per cycle.
// The result is registered; it is loaded into the output register once
// that register is free.
// One access is in flight at a time. A result that waits for rsp.ready does
// not block the next request transfer; only the following result waits,
// and the block holds req.ready low until rsp drains.
module banked_flash_command_decoder_unit (
	input logic       clk,
	input logic       arst_n,
	bfcd_req_if.sink  req,
	bfcd_rsp_if.source rsp
);

	bfcd_pkg::seq_dec_t dec;
	bfcd_pkg::dp_cmd_t  dp_cmd;
	bfcd_pkg::dp_sts_t  dp_sts;
	logic               bank;
	logic               is_write;
	logic               seq_update;

	assign is_write   = (req.cmd == bfcd_pkg::ACC_WRITE);
	assign seq_update = dp_cmd.accept && is_write;

	bfcd_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.update     (seq_update),
		.address    (req.address),
		.write_data (req.write_data),
		.dec        (dec),
		.bank       (bank)
	);

	bfcd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.is_write  (is_write),
		.dec       (dec),
		.sts       (dp_sts),
		.req_ready (req.ready),
		.cmd       (dp_cmd)
	);

	bfcd_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (dp_cmd),
		.is_write      (is_write),
		.address       (req.address),
		.write_data    (req.write_data),
		.bank          (bank),
		.ev            (dec.ev),
		.rsp_ready     (rsp.ready),
		.sts           (dp_sts),
		.rsp_valid     (rsp.valid),
		.rsp_read_data (rsp.read_data),
		.rsp_event_res (rsp.event_res)
	);

endmodule

// ----- design/bfcd_checker.sv -----
`timescale 1ns / 1ps
module bfcd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [7:0] rsp_read_data,
	input logic [2:0] rsp_event_res
);

	// hold a stalled result
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data) &&
		$stable(rsp_event_res))
		else $error("rsp payload changed under stall");

	a_write_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_event_res != bfcd_pkg::EV_NONE |-> rsp_read_data == 8'h00)
		else $error("event reported with non-zero read data");

	a_event_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_event_res == bfcd_pkg::EV_NONE ||
		rsp_event_res == bfcd_pkg::EV_BANK || rsp_event_res == bfcd_pkg::EV_ERASE ||
		rsp_event_res == bfcd_pkg::EV_PROGRAM || rsp_event_res == bfcd_pkg::EV_ABORT)
		else $error("undefined event code");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("second request taken while one is in flight");

endmodule

bind banked_flash_command_decoder_unit bfcd_checker u_bfcd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_read_data (rsp.read_data),
	.rsp_event_res (rsp.event_res)
);

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
	import bfcd_pkg::*;

	localparam int RANDOM_ITEMS   = 500;
	localparam int ERASE_BUDGET   = 20;
	localparam int MAX_WAIT       = 10;
	localparam int SETTLE_CYCLES  = 16;
	localparam int WATCHDOG_LIMIT = 3 * ARRAY_BYTES;
	localparam int REPORT_LINES   = 100;

	typedef struct packed {
		logic        cmd;
		logic [15:0] addr;
		logic [7:0]  data;
	} access_t;

	typedef struct packed {
		logic [7:0] read_data;
		event_t     ev;
	} reply_t;

	typedef struct packed {
		access_t acc;
		bit      typed;
		reply_t  rep;
	} step_row_t;

	logic clk = 1'b0;
	logic arst_n;

	bfcd_req_if req();
	bfcd_rsp_if rsp();

	banked_flash_command_decoder_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	seq_stage_t flash_stage = SEQ_IDLE;
	op_t        armed_op    = OP_NONE;
	logic       bank_sel    = 1'b0;
	logic [7:0] flash_image [ARRAY_BYTES];

	reply_t     awaited_replies [$];
	access_t    cmd_steps [$];
	step_row_t  directed_rows [$];
	logic [15:0] hot_addr [8];

	bit no_idle = 1'b0;
	int mismatches = 0;
	int idle_cycles = 0;
	int access_total = 0;
	int read_total = 0;
	int ev_tally [5] = '{default: 0};

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		if (mismatches < REPORT_LINES)
			$display("MISMATCH %s: got %0d, wanted %0d", what, got, want);
		mismatches++;
	endtask

	function automatic reply_t predict_reply(input access_t acc);
		reply_t      rep;
		int unsigned base;
		int unsigned sector;
		rep.read_data = DATA_ZERO;
		rep.ev = EV_NONE;
		base = bank_sel ? BANK_BYTES : 0;
		if (acc.cmd == ACC_READ) begin
			if (32'(acc.addr) < BANK_BYTES)
				rep.read_data = flash_image[base + acc.addr];
			else
				rep.read_data = DATA_ERASED;
			return rep;
		end
		case (flash_stage)
			SEQ_IDLE: begin
				if (acc.addr == ADDR_UNLOCK_A && acc.data == DATA_UNLOCK_A)
					flash_stage = SEQ_FIRST;
			end
			SEQ_FIRST: begin
				if (acc.addr == ADDR_UNLOCK_B && acc.data == DATA_UNLOCK_B)
					flash_stage = SEQ_UNLOCKED;
				else
					rep.ev = EV_ABORT;
			end
			SEQ_UNLOCKED: begin
				if (acc.addr != ADDR_UNLOCK_A)
					rep.ev = EV_ABORT;
				else if (acc.data == CMD_BANK) begin
					armed_op = OP_BANK;
					flash_stage = SEQ_OPERAND;
				end else if (acc.data == CMD_PROGRAM) begin
					armed_op = OP_PROGRAM;
					flash_stage = SEQ_OPERAND;
				end else if (acc.data == CMD_ERASE) begin
					armed_op = OP_ERASE;
					flash_stage = SEQ_ERASE_AA;
				end else
					rep.ev = EV_ABORT;
			end
			SEQ_ERASE_AA: begin
				if (acc.addr == ADDR_UNLOCK_A && acc.data == DATA_UNLOCK_A)
					flash_stage = SEQ_ERASE_55;
				else
					rep.ev = EV_ABORT;
			end
			SEQ_ERASE_55: begin
				if (acc.addr == ADDR_UNLOCK_B && acc.data == DATA_UNLOCK_B)
					flash_stage = SEQ_OPERAND;
				else
					rep.ev = EV_ABORT;
			end
			SEQ_OPERAND: begin
				case (armed_op)
					OP_BANK: begin
						if (acc.addr != ADDR_BANK)
							rep.ev = EV_ABORT;
						else begin
							bank_sel = (32'(acc.data[0]) < BANK_COUNT) ? acc.data[0] : 1'b0;
							rep.ev = EV_BANK;
						end
					end
					OP_PROGRAM: begin
						if (32'(acc.addr) >= BANK_BYTES)
							rep.ev = EV_ABORT;
						else begin
							flash_image[base + acc.addr] =
								flash_image[base + acc.addr] & acc.data;
							rep.ev = EV_PROGRAM;
						end
					end
					OP_ERASE: begin
						sector = 32'(acc.addr) >> SECTOR_SHIFT;
						if (acc.data != DATA_CONFIRM || sector >= SECTORS_PER_BANK)
							rep.ev = EV_ABORT;
						else begin
							for (int j = 0; j < SECTOR_BYTES; j++)
								flash_image[base + sector * SECTOR_BYTES + j] = DATA_ERASED;
							rep.ev = EV_ERASE;
						end
					end
					default: rep.ev = EV_ABORT;
				endcase
			end
			default: rep.ev = EV_ABORT;
		endcase
		// every reported event ends the sequence
		if (rep.ev != EV_NONE) begin
			flash_stage = SEQ_IDLE;
			armed_op = OP_NONE;
		end
		return rep;
	endfunction

	function automatic logic [15:0] pick_address();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 5)
			return hot_addr[$urandom_range(0, 7)];
		if (pick == 5)
			return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
		return 16'($urandom);
	endfunction

	function automatic step_row_t step_row(input logic cmd, input logic [15:0] addr,
			input logic [7:0] data, input bit typed, input logic [7:0] rd, input event_t ev);
		step_row_t row;
		row.acc = '{cmd, addr, data};
		row.typed = typed;
		row.rep = '{rd, ev};
		return row;
	endfunction

	task automatic bus_access(input access_t acc, input bit typed, input reply_t typed_rep);
		int     gap;
		reply_t rep;
		gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.cmd <= acc.cmd;
		req.address <= acc.addr;
		req.write_data <= acc.data;
		do @(posedge clk); while (!req.ready);
		rep = predict_reply(acc);
		awaited_replies.push_back(typed ? typed_rep : rep);
		access_total++;
		if (acc.cmd == ACC_READ)
			read_total++;
		ev_tally[int'(rep.ev)]++;
	endtask

	task automatic queue_command(input op_t op);
		cmd_steps.push_back('{ACC_WRITE, ADDR_UNLOCK_A, DATA_UNLOCK_A});
		cmd_steps.push_back('{ACC_WRITE, ADDR_UNLOCK_B, DATA_UNLOCK_B});
		case (op)
			OP_BANK: begin
				cmd_steps.push_back('{ACC_WRITE, ADDR_UNLOCK_A, CMD_BANK});
				cmd_steps.push_back('{ACC_WRITE,
					($urandom_range(0, 6) == 0) ? pick_address() : ADDR_BANK,
					8'($urandom)});
			end
			OP_PROGRAM: begin
				cmd_steps.push_back('{ACC_WRITE, ADDR_UNLOCK_A, CMD_PROGRAM});
				cmd_steps.push_back('{ACC_WRITE, pick_address(),
					8'($urandom) | 8'($urandom)});
			end
			OP_ERASE: begin
				cmd_steps.push_back('{ACC_WRITE, ADDR_UNLOCK_A, CMD_ERASE});
				cmd_steps.push_back('{ACC_WRITE, ADDR_UNLOCK_A, DATA_UNLOCK_A});
				cmd_steps.push_back('{ACC_WRITE, ADDR_UNLOCK_B, DATA_UNLOCK_B});
				cmd_steps.push_back('{ACC_WRITE, pick_address(),
					($urandom_range(0, 4) == 0) ? 8'($urandom) : DATA_CONFIRM});
			end
			default: ;
		endcase
	endtask

	// compare each reply transfer against the oldest awaited one
	always @(posedge clk or negedge arst_n) begin : reply_check
		reply_t want;
		if (!arst_n)
			idle_cycles <= 0;
		else begin
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (rsp.valid && rsp.ready) begin
				if (awaited_replies.size() == 0)
					report_mismatch("reply with nothing awaited", rsp.event_res, 0);
				else begin
					want = awaited_replies.pop_front();
					if (rsp.read_data !== want.read_data)
						report_mismatch("read_data", rsp.read_data, want.read_data);
					if (rsp.event_res !== want.ev)
						report_mismatch("event_res", rsp.event_res, want.ev);
				end
			end
		end
	end

	initial begin : reply_stall
		int stall;
		rsp.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
			if (stall > 0) begin
				rsp.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			do @(posedge clk); while (!rsp.valid);
		end
	end

	initial begin : watchdog
		while (idle_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
		$display("Regression FAIL");
		$finish;
	end

	initial begin : stimulus
		int      counted;
		int      erase_left;
		int      pick;
		int      keep;
		bit      broken;
		op_t     op;
		access_t rd_acc;
		reply_t  blank;
		blank = '{DATA_ZERO, EV_NONE};
		arst_n <= 1'b0;
		req.valid <= 1'b0;
		req.cmd <= ACC_READ;
		req.address <= 16'h0000;
		req.write_data <= DATA_ZERO;
		foreach (flash_image[i])
			flash_image[i] = DATA_ERASED;
		hot_addr[0] = 16'h0000;
		hot_addr[1] = 16'hFFFF;
		hot_addr[2] = ADDR_UNLOCK_A;
		hot_addr[3] = ADDR_UNLOCK_B;
		for (int i = 4; i < 8; i++)
			hot_addr[i] = 16'($urandom);

		directed_rows = '{
			step_row(ACC_READ,  16'h0000, 8'h00, 1, DATA_ERASED, EV_NONE),
			step_row(ACC_READ,  16'hFFFF, 8'h00, 1, DATA_ERASED, EV_NONE),
			step_row(ACC_WRITE, 16'h1234, DATA_UNLOCK_A, 1, DATA_ZERO, EV_NONE),
			step_row(ACC_WRITE, ADDR_UNLOCK_A, DATA_UNLOCK_A, 1, DATA_ZERO, EV_NONE),
			step_row(ACC_WRITE, ADDR_UNLOCK_B, DATA_UNLOCK_B, 1, DATA_ZERO, EV_NONE),
			step_row(ACC_WRITE, ADDR_UNLOCK_A, CMD_PROGRAM, 1, DATA_ZERO, EV_NONE),
			step_row(ACC_WRITE, 16'hFFFF, 8'h00, 1, DATA_ZERO, EV_PROGRAM),
			step_row(ACC_READ,  16'hFFFF, 8'h00, 1, DATA_ZERO, EV_NONE),
			step_row(ACC_WRITE, ADDR_UNLOCK_A, DATA_UNLOCK_A, 0, DATA_ZERO, EV_NONE),
			step_row(ACC_WRITE, ADDR_UNLOCK_B, DATA_UNLOCK_B, 0, DATA_ZERO, EV_NONE),
			step_row(ACC_WRITE, ADDR_UNLOCK_A, CMD_BANK, 0, DATA_ZERO, EV_NONE),
			step_row(ACC_WRITE, 16'h0001, 8'h01, 1, DATA_ZERO, EV_ABORT),
			step_row(ACC_WRITE, ADDR_UNLOCK_A, DATA_UNLOCK_A, 0, DATA_ZERO, EV_NONE),
			step_row(ACC_WRITE, ADDR_UNLOCK_B, DATA_UNLOCK_B, 0, DATA_ZERO, EV_NONE),
			step_row(ACC_WRITE, ADDR_UNLOCK_A, CMD_BANK, 0, DATA_ZERO, EV_NONE),
			step_row(ACC_WRITE, ADDR_BANK, 8'hFF, 1, DATA_ZERO, EV_BANK),
			step_row(ACC_WRITE, ADDR_UNLOCK_A, DATA_UNLOCK_A, 0, DATA_ZERO, EV_NONE),
			step_row(ACC_WRITE, ADDR_UNLOCK_A, DATA_UNLOCK_A, 1, DATA_ZERO, EV_ABORT),
			step_row(ACC_WRITE, ADDR_UNLOCK_A, DATA_UNLOCK_A, 0, DATA_ZERO, EV_NONE),
			step_row(ACC_WRITE, ADDR_UNLOCK_B, DATA_UNLOCK_B, 0, DATA_ZERO, EV_NONE),
			step_row(ACC_WRITE, ADDR_UNLOCK_A, CMD_ERASE, 0, DATA_ZERO, EV_NONE),
			step_row(ACC_READ,  16'hFFFF, 8'h00, 1, DATA_ERASED, EV_NONE),
			step_row(ACC_WRITE, ADDR_UNLOCK_A, DATA_UNLOCK_A, 0, DATA_ZERO, EV_NONE),
			step_row(ACC_WRITE, ADDR_UNLOCK_B, DATA_UNLOCK_B, 0, DATA_ZERO, EV_NONE),
			step_row(ACC_WRITE, 16'hF123, DATA_CONFIRM, 1, DATA_ZERO, EV_ERASE)
		};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			bus_access(directed_rows[i].acc, directed_rows[i].typed, directed_rows[i].rep);

		counted = 0;
		erase_left = ERASE_BUDGET;
		while (counted < RANDOM_ITEMS) begin
			if ($urandom_range(0, 19) == 0)
				no_idle = !no_idle;
			pick = $urandom_range(0, 99);
			broken = 1'b0;
			cmd_steps.delete();
			if (pick < 25)
				cmd_steps.push_back('{ACC_READ, pick_address(), 8'($urandom)});
			else if (pick < 88) begin
				if (pick < 55)
					op = OP_PROGRAM;
				else if (pick < 65)
					op = OP_BANK;
				else if (pick < 70)
					op = OP_ERASE;
				else begin
					broken = 1'b1;
					op = op_t'($urandom_range(OP_BANK, OP_ERASE));
				end
				if (op == OP_ERASE) begin
					if (erase_left == 0)
						op = OP_PROGRAM;
					else
						erase_left--;
				end
				queue_command(op);
				if (broken) begin
					// cut the sequence short and finish it with a stray write
					keep = $urandom_range(1, cmd_steps.size() - 1);
					while (cmd_steps.size() > keep)
						void'(cmd_steps.pop_back());
					cmd_steps.push_back('{ACC_WRITE, pick_address(), 8'($urandom)});
				end
			end else begin
				bus_access('{ACC_WRITE, 16'($urandom), 8'($urandom)}, 1'b0, blank);
			end
			foreach (cmd_steps[i]) begin
				if ($urandom_range(0, 9) == 0) begin
					rd_acc = '{ACC_READ, pick_address(), 8'($urandom)};
					bus_access(rd_acc, 1'b0, blank);
					counted++;
				end
				bus_access(cmd_steps[i], 1'b0, blank);
				counted++;
			end
		end

		req.valid <= 1'b0;
		wait (awaited_replies.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d bus accesses, %0d of them reads, after the power-up sweep",
			access_total, read_total);
		$display("Events: %0d bank switches, %0d sector erases, %0d programs, %0d aborts",
			ev_tally[EV_BANK], ev_tally[EV_ERASE], ev_tally[EV_PROGRAM], ev_tally[EV_ABORT]);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ----- banked_flash_command_decoder_unit.f -----
design/bfcd_pkg.sv
design/bfcd_req_if.sv
design/bfcd_rsp_if.sv
design/bfcd_seq.sv
design/bfcd_ctrl.sv
design/bfcd_dp.sv
design/banked_flash_command_decoder_unit.sv
design/bfcd_checker.sv
verif/testbench.sv
